[rtl/gbm_pkg.sv]
// ----------------------------------------------------------------------------
// gbm_pkg
// Types and constants shared by the GPIO bank: beat payloads, action codes,
// register map and version word.
// ----------------------------------------------------------------------------
package gbm_pkg;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   // register map by address[6:3]; address[2] picks the upper half
   typedef enum logic [3:0] {
      PAIR_DATA       = 4'd0,
      PAIR_DIR        = 4'd1,
      PAIR_IRQ_EN     = 4'd2,
      PAIR_IRQ_MASK   = 4'd3,
      PAIR_IRQ_TYPE   = 4'd4,
      PAIR_IRQ_POL    = 4'd5,
      PAIR_IRQ_BOTH   = 4'd6,
      PAIR_DEBOUNCE   = 4'd7,
      PAIR_DIV_ON     = 4'd8,
      PAIR_DIV_LIMIT  = 4'd9,
      PAIR_STATUS     = 4'd10,
      PAIR_RAW_STATUS = 4'd11,
      PAIR_EOI        = 4'd12,
      PAIR_EXT_PORT   = 4'd14,
      PAIR_VERSION    = 4'd15
   } reg_pair_type;

   localparam logic [31:0] VERSION_ID = 32'h0100_0C2B;

   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  address;
      logic [31:0] write_data;
      logic [31:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] pin_drive;
      logic [31:0] pin_direction;
      logic        interrupt_line;
   } rsp_type;

endpackage

[rtl/gbm_regs.sv]
// ----------------------------------------------------------------------------
// gbm_regs
// Register file of the GPIO bank: split-register bus access, pin sampling
// with debounce, interrupt detection. Updates state on a fired beat and
// presents that beat's result combinationally.
// ----------------------------------------------------------------------------
module gbm_regs
   import gbm_pkg::*;
#(
   parameter int NUM_PINS     = 32,
   parameter int DIVIDER_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   localparam int P = NUM_PINS;
   localparam int D = DIVIDER_BITS;

   logic [P-1:0] out_data_ff, out_data_in;
   logic [P-1:0] out_en_ff, out_en_in;
   logic [P-1:0] irq_en_ff, irq_en_in;
   logic [P-1:0] irq_mask_ff, irq_mask_in;
   logic [P-1:0] irq_edge_ff, irq_edge_in;
   logic [P-1:0] irq_pol_ff, irq_pol_in;
   logic [P-1:0] irq_both_ff, irq_both_in;
   logic [P-1:0] debounce_ff, debounce_in;
   logic [P-1:0] div_on_ff, div_on_in;
   logic [P-1:0] raw_ff, raw_in;
   logic [P-1:0] filt_ff, filt_in;
   logic [P-1:0] last_ff, last_in;
   logic [D-1:0] div_lim_ff, div_lim_in;
   logic [D-1:0] div_cnt_ff, div_cnt_in;

   reg_pair_type pair;
   logic         hi;
   logic [31:0]  en32, bits32;
   logic [P-1:0] touched, bits;
   logic [31:0]  rd;

   logic         strobe;
   logic [P-1:0] pins, sample_en, stable, upd, now_lvl;
   logic [P-1:0] rise, fall, edge_pins, det, lvl;

   function automatic logic [31:0] half_rd(logic [P-1:0] r, logic upper);
      logic [31:0] w;
      w = 32'(r);
      return upper ? {16'b0, w[31:16]} : {16'b0, w[15:0]};
   endfunction

   function automatic logic [P-1:0] merge(logic [P-1:0] r, logic [P-1:0] t,
                                          logic [P-1:0] b);
      return (r & ~t) | b;
   endfunction

   assign pair    = reg_pair_type'(item.address[6:3]);
   assign hi      = item.address[2];
   assign en32    = {16'b0, item.write_data[31:16]} << (hi ? 16 : 0);
   assign bits32  = {16'b0, item.write_data[31:16] & item.write_data[15:0]}
                    << (hi ? 16 : 0);
   assign touched = en32[P-1:0];
   assign bits    = bits32[P-1:0];

   // pin sampling
   assign strobe     = (div_cnt_ff == div_lim_ff);
   assign pins       = item.pin_levels[P-1:0];
   assign sample_en  = strobe ? {P{1'b1}} : ~div_on_ff;
   assign stable     = ~(pins ^ last_ff) & sample_en;
   assign upd        = (filt_ff & ~stable) | (pins & stable);
   assign now_lvl    = (pins & ~debounce_ff) | (upd & debounce_ff);
   assign rise       = now_lvl & ~filt_ff;
   assign fall       = filt_ff & ~now_lvl;
   assign edge_pins  = irq_edge_ff | irq_both_ff;
   assign det        = (irq_both_ff & (rise | fall)) |
                       (~irq_both_ff & ((irq_pol_ff & rise) | (~irq_pol_ff & fall)));
   assign lvl        = ~(now_lvl ^ irq_pol_ff);

   always_comb begin
      out_data_in = out_data_ff;
      out_en_in   = out_en_ff;
      irq_en_in   = irq_en_ff;
      irq_mask_in = irq_mask_ff;
      irq_edge_in = irq_edge_ff;
      irq_pol_in  = irq_pol_ff;
      irq_both_in = irq_both_ff;
      debounce_in = debounce_ff;
      div_on_in   = div_on_ff;
      raw_in      = raw_ff;
      filt_in     = filt_ff;
      last_in     = last_ff;
      div_lim_in  = div_lim_ff;
      div_cnt_in  = div_cnt_ff;
      rd          = '0;
      if (fire) begin
         unique case (action_type'(item.action))
            ACT_READ: begin
               unique case (pair)
                  PAIR_DATA:       rd = half_rd(out_data_ff, hi);
                  PAIR_DIR:        rd = half_rd(out_en_ff, hi);
                  PAIR_IRQ_EN:     rd = half_rd(irq_en_ff, hi);
                  PAIR_IRQ_MASK:   rd = half_rd(irq_mask_ff, hi);
                  PAIR_IRQ_TYPE:   rd = half_rd(irq_edge_ff, hi);
                  PAIR_IRQ_POL:    rd = half_rd(irq_pol_ff, hi);
                  PAIR_IRQ_BOTH:   rd = half_rd(irq_both_ff, hi);
                  PAIR_DEBOUNCE:   rd = half_rd(debounce_ff, hi);
                  PAIR_DIV_ON:     rd = half_rd(div_on_ff, hi);
                  PAIR_DIV_LIMIT:  rd = hi ? '0 : 32'(div_lim_ff);
                  PAIR_STATUS:     rd = hi ? '0 : 32'(raw_ff & irq_en_ff & ~irq_mask_ff);
                  PAIR_RAW_STATUS: rd = hi ? '0 : 32'(raw_ff);
                  PAIR_EXT_PORT:   rd = hi ? '0 : 32'(filt_ff);
                  PAIR_VERSION:    rd = hi ? '0 : VERSION_ID;
                  default:         rd = '0;
               endcase
            end
            ACT_WRITE: begin
               unique case (pair)
                  PAIR_DATA:     out_data_in = merge(out_data_ff, touched, bits);
                  PAIR_DIR:      out_en_in   = merge(out_en_ff, touched, bits);
                  PAIR_IRQ_EN: begin
                     irq_en_in = merge(irq_en_ff, touched, bits);
                     raw_in    = raw_ff & irq_en_in;
                  end
                  PAIR_IRQ_MASK: irq_mask_in = merge(irq_mask_ff, touched, bits);
                  PAIR_IRQ_TYPE: irq_edge_in = merge(irq_edge_ff, touched, bits);
                  PAIR_IRQ_POL:  irq_pol_in  = merge(irq_pol_ff, touched, bits);
                  PAIR_IRQ_BOTH: irq_both_in = merge(irq_both_ff, touched, bits);
                  PAIR_DEBOUNCE: debounce_in = merge(debounce_ff, touched, bits);
                  PAIR_DIV_ON:   div_on_in   = merge(div_on_ff, touched, bits);
                  PAIR_DIV_LIMIT: begin
                     if (!hi) begin
                        div_lim_in = item.write_data[D-1:0];
                     end
                  end
                  PAIR_EOI:      raw_in = raw_ff & ~(bits & edge_pins);
                  default:       raw_in = raw_ff;
               endcase
            end
            ACT_TICK: begin
               div_cnt_in = strobe ? '0 : div_cnt_ff + D'(1);
               last_in    = (last_ff & ~sample_en) | (pins & sample_en);
               filt_in    = now_lvl;
               raw_in     = (((raw_ff | det) & edge_pins) | (lvl & ~edge_pins))
                            & irq_en_ff;
            end
            default: rd = '0;
         endcase
      end
   end

   assign result.read_data      = rd;
   assign result.pin_drive      = 32'(out_data_in);
   assign result.pin_direction  = 32'(out_en_in);
   assign result.interrupt_line = |(raw_in & irq_en_in & ~irq_mask_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_data_ff <= '0;
         out_en_ff   <= '0;
         irq_en_ff   <= '0;
         irq_mask_ff <= '0;
         irq_edge_ff <= '0;
         irq_pol_ff  <= '0;
         irq_both_ff <= '0;
         debounce_ff <= '0;
         div_on_ff   <= '0;
         raw_ff      <= '0;
         filt_ff     <= '0;
         last_ff     <= '0;
         div_lim_ff  <= '0;
         div_cnt_ff  <= '0;
      end else begin
         out_data_ff <= out_data_in;
         out_en_ff   <= out_en_in;
         irq_en_ff   <= irq_en_in;
         irq_mask_ff <= irq_mask_in;
         irq_edge_ff <= irq_edge_in;
         irq_pol_ff  <= irq_pol_in;
         irq_both_ff <= irq_both_in;
         debounce_ff <= debounce_in;
         div_on_ff   <= div_on_in;
         raw_ff      <= raw_in;
         filt_ff     <= filt_in;
         last_ff     <= last_in;
         div_lim_ff  <= div_lim_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

endmodule

[rtl/gpio_bank_masked_write_irq_top.sv]
// ----------------------------------------------------------------------------
// gpio_bank_masked_write_irq_top
// 32-pin GPIO bank with split masked-write registers, debounced sampling
// and edge/level interrupt detection.
//
//   channel | dir | payload  | one beat
//   req_    | in  | req_type | bus read, bus write or pin-sample tick
//   rsp_    | out | rsp_type | read data, pin drive/direction, irq line
//
// One beat per clock sustained while rsp_ is not stalled; a request's
// result reaches rsp_ through the input register, then the register update
// and result register on the same edge.
// Synchronous reset zeroes both valid flags and the register file.
// A stalled rsp_ holds its beat; req_ stays ready while the input register
// is empty or its beat can move into the result register.
// ----------------------------------------------------------------------------
module gpio_bank_masked_write_irq_top
   import gbm_pkg::*;
#(
   parameter int NUM_PINS     = 32,
   parameter int DIVIDER_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_vld_ff, in_vld_in;
   req_type in_item_ff;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    out_free;
   logic    fire;

   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;
   assign rsp_vld_in = out_free ? fire : rsp_vld_ff;

   gbm_regs #(
      .NUM_PINS     (NUM_PINS),
      .DIVIDER_BITS (DIVIDER_BITS)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/gbm_checker.sv]
// ----------------------------------------------------------------------------
// gbm_checker
// Port-level checks on the GPIO bank: reset state, stall hold and
// back-to-back acceptance.
// ----------------------------------------------------------------------------
module gbm_checker
   import gbm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // out of reset: nothing pending, ready to take a beat
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

   // an empty result register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // while a result is taken, the request side is ready for a new request
   a_ready_after_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("req stalled while output drains");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // a new result needs an earlier request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid, 2) || $past(rsp_valid, 2) ||
                           !$past(req_ready, 2) || $past(req_valid, 3))
      else $error("result without request");

endmodule

bind gpio_bank_masked_write_irq_top gbm_checker u_gbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/gbm_bank_check.sv]
// ----------------------------------------------------------------------------
// gbm_bank_check
// Watches both channels of the GPIO bank, predicts each response beat from
// its own copy of the register file, pin filter and interrupt state, and
// compares every accepted response beat field by field, in order.
// ----------------------------------------------------------------------------
module gbm_bank_check
   import gbm_pkg::*;
#(
   parameter int NUM_PINS     = 32,
   parameter int DIVIDER_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_total,
   output int      results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] PIN_MASK = 32'hFFFF_FFFF >> (32 - NUM_PINS);
   localparam logic [31:0] DIV_MASK = 32'hFFFF_FFFF >> (32 - DIVIDER_BITS);

   // split registers, indexed by register pair
   logic [31:0] bank_q [0:8];
   logic [31:0] div_limit_q, div_count_q, raw_q, filtered_q, last_q;
   rsp_type     owed_results [$];
   int          fault_count = 0;

   function automatic rsp_type bank_next(input req_type r);
      rsp_type     res;
      logic [3:0]  pair;
      logic        upper;
      logic [15:0] en;
      logic        strobe;
      logic [31:0] touched, bits, pins, sample_en, stable, upd, old_f, now_f;
      logic [31:0] rise, fall, edge_pins, det, lvl;
      pair    = r.address[6:3];
      upper   = r.address[2];
      en      = r.write_data[31:16];
      touched = (upper ? {en, 16'h0} : {16'h0, en}) & PIN_MASK;
      bits    = touched & (upper ? {r.write_data[15:0], 16'h0}
                                 : {16'h0, r.write_data[15:0]});
      res     = '0;
      case (r.action)
         ACT_READ: begin
            if (pair <= PAIR_DIV_ON) begin
               res.read_data = upper ? {16'h0, bank_q[pair][31:16]}
                                     : {16'h0, bank_q[pair][15:0]};
            end else if (!upper) begin
               case (pair)
                  PAIR_DIV_LIMIT:  res.read_data = div_limit_q;
                  PAIR_STATUS:     res.read_data = raw_q & bank_q[PAIR_IRQ_EN]
                                                   & ~bank_q[PAIR_IRQ_MASK];
                  PAIR_RAW_STATUS: res.read_data = raw_q;
                  PAIR_EXT_PORT:   res.read_data = filtered_q;
                  PAIR_VERSION:    res.read_data = VERSION_ID;
                  default: ;
               endcase
            end
         end
         ACT_WRITE: begin
            if (pair <= PAIR_DIV_ON) begin
               bank_q[pair] = (bank_q[pair] & ~touched) | bits;
               if (pair == PAIR_IRQ_EN)
                  raw_q = raw_q & bank_q[PAIR_IRQ_EN];
            end else if (pair == PAIR_DIV_LIMIT && !upper) begin
               div_limit_q = r.write_data & DIV_MASK;
            end else if (pair == PAIR_EOI) begin
               raw_q = raw_q & ~(bits & (bank_q[PAIR_IRQ_TYPE] | bank_q[PAIR_IRQ_BOTH]));
            end
         end
         ACT_TICK: begin
            strobe      = (div_count_q == div_limit_q);
            div_count_q = strobe ? '0 : ((div_count_q + 1) & DIV_MASK);
            pins        = r.pin_levels & PIN_MASK;
            sample_en   = strobe ? PIN_MASK : (~bank_q[PAIR_DIV_ON] & PIN_MASK);
            stable      = ~(pins ^ last_q) & sample_en;
            upd         = (filtered_q & ~stable) | (pins & stable);
            last_q      = (last_q & ~sample_en) | (pins & sample_en);
            old_f       = filtered_q;
            now_f       = ((pins & ~bank_q[PAIR_DEBOUNCE]) | (upd & bank_q[PAIR_DEBOUNCE]))
                          & PIN_MASK;
            filtered_q  = now_f;
            rise        = now_f & ~old_f;
            fall        = old_f & ~now_f;
            edge_pins   = bank_q[PAIR_IRQ_TYPE] | bank_q[PAIR_IRQ_BOTH];
            det         = (bank_q[PAIR_IRQ_BOTH] & (rise | fall)) |
                          (~bank_q[PAIR_IRQ_BOTH] & ((bank_q[PAIR_IRQ_POL] & rise) |
                                                     (~bank_q[PAIR_IRQ_POL] & fall)));
            lvl         = ~(now_f ^ bank_q[PAIR_IRQ_POL]);
            raw_q       = (((raw_q | det) & edge_pins) | (lvl & ~edge_pins))
                          & bank_q[PAIR_IRQ_EN] & PIN_MASK;
         end
         default: ;
      endcase
      res.pin_drive      = bank_q[PAIR_DATA];
      res.pin_direction  = bank_q[PAIR_DIR];
      res.interrupt_line = |(raw_q & bank_q[PAIR_IRQ_EN] & ~bank_q[PAIR_IRQ_MASK]);
      return res;
   endfunction

   task automatic log_fault(input string msg);
      if (fault_count < 10)
         $display("%s", msg);
      fault_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i <= 8; i++)
            bank_q[i] = '0;
         div_limit_q = '0;
         div_count_q = '0;
         raw_q       = '0;
         filtered_q  = '0;
         last_q      = '0;
         owed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               log_fault($sformatf("unexpected response beat %h", rsp_data));
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.read_data !== want.read_data ||
                   rsp_data.pin_drive !== want.pin_drive ||
                   rsp_data.pin_direction !== want.pin_direction ||
                   rsp_data.interrupt_line !== want.interrupt_line)
                  log_fault($sformatf(
                     "mismatch exp/act: read %h/%h drive %h/%h dir %h/%h irq %b/%b",
                     want.read_data, rsp_data.read_data,
                     want.pin_drive, rsp_data.pin_drive,
                     want.pin_direction, rsp_data.pin_direction,
                     want.interrupt_line, rsp_data.interrupt_line));
            end
         end
         if (req_valid && req_ready)
            owed_results.push_back(bank_next(req_data));
      end
      results_owed   <= owed_results.size();
      mismatch_total <= fault_count;
   end

endmodule

[tb/gpio_bank_masked_write_irq_top_tb.sv]
// ----------------------------------------------------------------------------
// gpio_bank_masked_write_irq_top_tb
// Drives bus reads, masked writes and pin-sample ticks into the GPIO bank:
// a directed pass over the register map and interrupt corner cases, then
// random phases with varying sender gaps, receiver stalls and divider
// settings. Response checking is done by gbm_bank_check.
// ----------------------------------------------------------------------------
module gpio_bank_masked_write_irq_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gbm_pkg::*;

   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam logic [3:0] PAIR_UNUSED = 4'd13;
   localparam int         QUIET_LIMIT = 4000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int          mismatch_total;
   int          results_owed;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          quiet     = 0;
   logic [31:0] pin_state = '0;

   int send_idle  [5] = '{0, 80, 0, 22, 0};
   int recv_stall [5] = '{0, 0, 80, 22, 0};
   int div_limits [5] = '{1, 2, 3, 6, 11};

   gpio_bank_masked_write_irq_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gbm_bank_check bank_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_total (mismatch_total),
      .results_owed   (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [6:0] reg_addr(input reg_pair_type pair, input logic upper);
      return {pair, upper, 2'b00};
   endfunction

   function automatic req_type make_beat(input action_type act, input logic [6:0] addr,
                                         input logic [31:0] wd, input logic [31:0] pins);
      req_type b;
      b.action     = act;
      b.address    = addr;
      b.write_data = wd;
      b.pin_levels = pins;
      return b;
   endfunction

   // mostly well-formed traffic: ticks with slowly changing pins, masked
   // writes to the split registers, reads of mapped registers, some noise
   function automatic req_type random_beat();
      req_type b;
      int      pick;
      b.action     = ACT_TICK;
      b.address    = 7'($urandom);
      b.write_data = $urandom;
      b.pin_levels = $urandom;
      pick         = $urandom_range(99);
      if (pick < 40) begin
         case ($urandom_range(3))
            0, 1: ;
            2: pin_state = pin_state ^ ($urandom & $urandom);
            default: pin_state = $urandom;
         endcase
         b.pin_levels = pin_state;
      end else if (pick < 70) begin
         b.action = ACT_WRITE;
         if ($urandom_range(3) == 0)
            b.write_data[31:16] = 16'hFFFF;
         if ($urandom_range(5) == 0)
            b.address[6:3] = PAIR_EOI;
         else
            b.address[6:3] = 4'($urandom_range(PAIR_DIV_ON));
      end else if (pick < 92) begin
         b.action = ACT_READ;
         case ($urandom_range(6))
            0: b.address[6:3] = PAIR_DIV_LIMIT;
            1: b.address[6:3] = PAIR_STATUS;
            2: b.address[6:3] = PAIR_RAW_STATUS;
            3: b.address[6:3] = PAIR_EXT_PORT;
            4: b.address[6:3] = PAIR_VERSION;
            default: b.address[6:3] = 4'($urandom_range(PAIR_DIV_ON));
         endcase
      end else begin
         b.action = 2'($urandom);
         // keep the divider limit under phase control
         if (b.address[6:3] == PAIR_DIV_LIMIT)
            b.address[2] = 1'b1;
      end
      return b;
   endfunction

   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_bank();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   initial begin
      req_type odd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: register map and interrupt corners
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_VERSION, 1'b0), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DIV_LIMIT, 1'b0), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_DIV_LIMIT, 1'b0), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DIV_LIMIT, 1'b0), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DATA, 1'b0), 32'hFFFF_A5A5, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DATA, 1'b1), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DATA, 1'b0), 32'h0000_FFFF, '0));
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_DATA, 1'b0) | 7'd3, '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DIR, 1'b1), 32'h00FF_1234, '0));
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_DIR, 1'b1), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_EN, 1'b0), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_EN, 1'b1), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_TYPE, 1'b1), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_POL, 1'b0), 32'hFFFF_00FF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_BOTH, 1'b1), 32'hFF00_FF00, '0));
      send_beat(make_beat(ACT_TICK,  '0, '0, 32'h0000_0000));
      send_beat(make_beat(ACT_TICK,  '0, '0, 32'hFFFF_FFFF));
      send_beat(make_beat(ACT_TICK,  '0, '0, 32'h0000_0000));
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_RAW_STATUS, 1'b0), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_MASK, 1'b0), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_STATUS, 1'b0), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_EOI, 1'b1), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_EOI, 1'b0), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_EOI, 1'b0), '0, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_IRQ_EN, 1'b1), 32'hFFFF_0000, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_STATUS, 1'b0), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_VERSION, 1'b0), 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_WRITE, {PAIR_UNUSED, 3'b000}, 32'hFFFF_FFFF, '0));
      send_beat(make_beat(ACT_READ,  {PAIR_UNUSED, 3'b000}, '0, '0));
      odd            = random_beat();
      odd.action     = ACT_NONE;
      send_beat(odd);
      send_beat(make_beat(ACT_READ,  reg_addr(PAIR_EXT_PORT, 1'b0), '0, '0));

      // random phases; each starts from an empty pipeline
      for (int p = 0; p < 5; p++) begin
         drain_bank();
         idle_pct  = send_idle[p];
         stall_pct = recv_stall[p];
         send_beat(make_beat(ACT_WRITE, reg_addr(PAIR_DIV_LIMIT, 1'b0), div_limits[p], '0));
         repeat (100) send_beat(random_beat());
      end

      drain_bank();
      repeat (8) @(posedge clock);
      if (mismatch_total == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
